// ----- rtl/bfa_pkg.sv -----
// Shared types and constants of the buddy frame allocator.
package bfa_pkg;

	// Default pool geometry
	localparam int NUM_FRAMES_DEF = 1024;
	localparam int TOP_ORDER_DEF  = 7;

	// Frame tag codes beside the free head orders
	localparam logic [3:0] TAG_ALLOC     = 4'd13;
	localparam logic [3:0] TAG_FREE_BODY = 4'd15;

	// Request kinds
	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	// Sequencer states
	typedef enum logic [4:0] {
		S_INIT,
		S_IDLE,
		S_SCAN,
		S_SPLIT_RM,
		S_SPLIT_TAG1,
		S_SPLIT_TAG2,
		S_SPLIT_AP2,
		S_SPLIT_NEXT,
		S_TAKE,
		S_MARK,
		S_FR_RD,
		S_FR_CHK,
		S_MG_RD,
		S_MG_CHK,
		S_MG_RM2,
		S_MG_T1,
		S_MG_T2,
		S_MG_NXT,
		S_RM_RD,
		S_RM_LNK,
		S_RM_CLR,
		S_AP_A,
		S_AP_B,
		S_DONE
	} state_t;

endpackage

// ----- rtl/buddy_frame_allocator_top.sv -----
// Buddy frame allocator: sequencer, tag and link memories, per-order free lists.
// After reset the block runs a clearing pass over all NUM_FRAMES frames that writes the
// initial tags and links, and accepts no item until it ends. One item is worked at a
// time through a small sequencer over tag and link memories with one write and one
// registered read port each. An allocate scans the free lists upward from the requested
// order, splits a larger block level by level, and then tags each of the 2^order frames
// of the block allocated. A free checks the frame's tag, puts it on the order-0 list and
// then merges with its buddy level by level. A finished result sits in an output register
// while the next item is taken.
module buddy_frame_allocator_top #(
	parameter int NUM_FRAMES = bfa_pkg::NUM_FRAMES_DEF,
	parameter int TOP_ORDER  = bfa_pkg::TOP_ORDER_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // order [3:0], frame_number [13:4], zero fill
	input  logic [0:0]  s_tuser,  // func [0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // block_start [9:0], zero fill
	output logic [0:0]  m_tuser   // status [0]
);

	localparam int FW       = $clog2(NUM_FRAMES);
	localparam int LW       = $clog2(NUM_FRAMES + 1);
	localparam int OW       = $clog2(TOP_ORDER + 1);
	localparam int CW       = TOP_ORDER + 1;
	localparam int TOP_SIZE = 1 << TOP_ORDER;
	localparam int TOP_BLKS = NUM_FRAMES / TOP_SIZE;
	localparam int TOP_END  = TOP_BLKS * TOP_SIZE;
	localparam logic [LW-1:0] NO_LINK   = LW'(NUM_FRAMES);
	localparam logic [LW-1:0] TOP_HEAD0 = (TOP_BLKS > 0) ? LW'(0) : NO_LINK;
	localparam logic [LW-1:0] TOP_TAIL0 = (TOP_BLKS > 0) ? LW'(TOP_END - TOP_SIZE) : NO_LINK;

	// Input fields
	logic       in_func;
	logic [3:0] in_order;
	logic [9:0] in_fn;
	assign in_func  = s_tuser[0];
	assign in_order = s_tdata[3:0];
	assign in_fn    = s_tdata[13:4];

	bfa_pkg::state_t state_q, state_d, ret_q, call_ret;

	// Memories
	logic [3:0]    tag_mem  [NUM_FRAMES];
	logic [LW-1:0] next_mem [NUM_FRAMES];
	logic [LW-1:0] prev_mem [NUM_FRAMES];

	logic          tag_we, next_we, prev_we;
	logic [FW-1:0] tag_wa, tag_ra, next_wa, prev_wa, link_ra;
	logic [3:0]    tag_wd, tag_rd_q;
	logic [LW-1:0] next_wd, prev_wd, next_rd_q, prev_rd_q;

	// Free list ends
	logic [LW-1:0] head_q [TOP_ORDER+1];
	logic [LW-1:0] tail_q [TOP_ORDER+1];

	// Working registers
	logic [LW-1:0] op_f_q, ap_t_q, f_q, g_q, idx_q, b_q;
	logic [OW-1:0] op_o_q, u_q, ord_q;
	logic [CW-1:0] cnt_q;
	logic [FW-1:0] init_q;
	logic          out_valid_q, out_status_q;
	logic [9:0]    out_start_q;
	logic          res_status_q;
	logic [9:0]    res_start_q;

	// Sequencer control
	logic          call_rm, call_ap, fin, fin_status, load_out;
	logic [LW-1:0] call_f;
	logic [OW-1:0] call_o;
	logic [9:0]    fin_start;

	// Derived values
	logic [31:0]   init_ext, gsum, bx, mark_a;
	logic          init_top;
	logic [OW-1:0] u_dn;
	logic [CW-1:0] cnt_nx, blk_size;
	logic          mark_end;
	logic [LW-1:0] lo_f, hi_f, rm_p, rm_n, ap_t;
	logic          ap_empty;

	assign init_ext = 32'(init_q);
	assign init_top = (init_ext % TOP_SIZE == 0) && (init_ext < TOP_END);
	assign u_dn     = u_q - OW'(1);
	assign gsum     = 32'(f_q) + (32'd1 << u_dn);
	assign bx       = 32'(idx_q) ^ (32'd1 << u_q);
	assign mark_a   = 32'(f_q) + 32'(cnt_q);
	assign cnt_nx   = cnt_q + CW'(1);
	assign blk_size = CW'(1) << ord_q;
	assign mark_end = (cnt_nx == blk_size) || (mark_a + 32'd1 >= NUM_FRAMES);
	assign lo_f     = (b_q < idx_q) ? b_q : idx_q;
	assign hi_f     = (b_q < idx_q) ? idx_q : b_q;
	assign rm_p     = prev_rd_q;
	assign rm_n     = next_rd_q;
	assign ap_t     = tail_q[op_o_q];
	assign ap_empty = (head_q[op_o_q] == NO_LINK) || (ap_t == NO_LINK);

	// Next state, memory control and calls
	always_comb begin
		state_d    = state_q;
		s_tready   = 1'b0;
		tag_we     = 1'b0;
		tag_wa     = f_q[FW-1:0];
		tag_wd     = bfa_pkg::TAG_ALLOC;
		tag_ra     = idx_q[FW-1:0];
		next_we    = 1'b0;
		next_wa    = op_f_q[FW-1:0];
		next_wd    = NO_LINK;
		prev_we    = 1'b0;
		prev_wa    = op_f_q[FW-1:0];
		prev_wd    = NO_LINK;
		link_ra    = op_f_q[FW-1:0];
		call_rm    = 1'b0;
		call_ap    = 1'b0;
		call_f     = f_q;
		call_o     = u_q;
		call_ret   = bfa_pkg::S_IDLE;
		fin        = 1'b0;
		fin_status = 1'b1;
		fin_start  = '0;
		load_out   = 1'b0;
		unique case (state_q)
			bfa_pkg::S_INIT: begin
				tag_we  = 1'b1;
				tag_wa  = init_q;
				tag_wd  = init_top ? 4'(TOP_ORDER) : bfa_pkg::TAG_FREE_BODY;
				next_we = 1'b1;
				next_wa = init_q;
				next_wd = (init_top && init_ext + TOP_SIZE < TOP_END) ?
					LW'(init_ext + TOP_SIZE) : NO_LINK;
				prev_we = 1'b1;
				prev_wa = init_q;
				prev_wd = (init_top && init_ext != 0) ? LW'(init_ext - TOP_SIZE) : NO_LINK;
				if (32'(init_q) == NUM_FRAMES - 1) state_d = bfa_pkg::S_IDLE;
			end
			bfa_pkg::S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (in_func == bfa_pkg::FUNC_FREE) begin
						if (32'(in_fn) < NUM_FRAMES) state_d = bfa_pkg::S_FR_RD;
						else fin = 1'b1;
					end else begin
						if (32'(in_order) > TOP_ORDER) fin = 1'b1;
						else state_d = bfa_pkg::S_SCAN;
					end
				end
			end
			bfa_pkg::S_SCAN: begin
				if (head_q[u_q] != NO_LINK) begin
					state_d = (u_q == ord_q) ? bfa_pkg::S_TAKE : bfa_pkg::S_SPLIT_RM;
				end else if (u_q == OW'(TOP_ORDER)) begin
					fin = 1'b1;
				end
			end
			bfa_pkg::S_SPLIT_RM: begin
				call_rm  = 1'b1;
				call_f   = head_q[u_q];
				call_ret = bfa_pkg::S_SPLIT_TAG1;
			end
			bfa_pkg::S_SPLIT_TAG1: begin
				if (gsum >= NUM_FRAMES) begin
					fin = 1'b1;
				end else begin
					tag_we  = 1'b1;
					tag_wd  = 4'(u_dn);
					state_d = bfa_pkg::S_SPLIT_TAG2;
				end
			end
			bfa_pkg::S_SPLIT_TAG2: begin
				tag_we   = 1'b1;
				tag_wa   = g_q[FW-1:0];
				tag_wd   = 4'(u_q);
				call_ap  = 1'b1;
				call_ret = bfa_pkg::S_SPLIT_AP2;
			end
			bfa_pkg::S_SPLIT_AP2: begin
				call_ap  = 1'b1;
				call_f   = g_q;
				call_ret = bfa_pkg::S_SPLIT_NEXT;
			end
			bfa_pkg::S_SPLIT_NEXT: begin
				state_d = (u_q > ord_q) ? bfa_pkg::S_SPLIT_RM : bfa_pkg::S_TAKE;
			end
			bfa_pkg::S_TAKE: begin
				if (head_q[ord_q] == NO_LINK) begin
					fin = 1'b1;
				end else begin
					call_rm  = 1'b1;
					call_f   = head_q[ord_q];
					call_o   = ord_q;
					call_ret = bfa_pkg::S_MARK;
				end
			end
			bfa_pkg::S_MARK: begin
				tag_we = 1'b1;
				tag_wa = mark_a[FW-1:0];
				if (mark_end) begin
					fin        = 1'b1;
					fin_status = 1'b0;
					fin_start  = 10'(f_q);
				end
			end
			bfa_pkg::S_FR_RD: begin
				state_d = bfa_pkg::S_FR_CHK;
			end
			bfa_pkg::S_FR_CHK: begin
				if (tag_rd_q != bfa_pkg::TAG_ALLOC) begin
					fin = 1'b1;
				end else begin
					tag_we   = 1'b1;
					tag_wa   = idx_q[FW-1:0];
					tag_wd   = 4'd0;
					call_ap  = 1'b1;
					call_f   = idx_q;
					call_o   = '0;
					call_ret = bfa_pkg::S_MG_RD;
				end
			end
			bfa_pkg::S_MG_RD: begin
				if (u_q == OW'(TOP_ORDER) || bx >= NUM_FRAMES) begin
					fin        = 1'b1;
					fin_status = 1'b0;
				end else begin
					tag_ra  = bx[FW-1:0];
					state_d = bfa_pkg::S_MG_CHK;
				end
			end
			bfa_pkg::S_MG_CHK: begin
				if (tag_rd_q != 4'(u_q)) begin
					fin        = 1'b1;
					fin_status = 1'b0;
				end else begin
					call_rm  = 1'b1;
					call_f   = b_q;
					call_ret = bfa_pkg::S_MG_RM2;
				end
			end
			bfa_pkg::S_MG_RM2: begin
				call_rm  = 1'b1;
				call_f   = idx_q;
				call_ret = bfa_pkg::S_MG_T1;
			end
			bfa_pkg::S_MG_T1: begin
				tag_we  = 1'b1;
				tag_wa  = lo_f[FW-1:0];
				tag_wd  = 4'(u_q) + 4'd1;
				state_d = bfa_pkg::S_MG_T2;
			end
			bfa_pkg::S_MG_T2: begin
				tag_we   = 1'b1;
				tag_wa   = b_q[FW-1:0];
				tag_wd   = bfa_pkg::TAG_FREE_BODY;
				call_ap  = 1'b1;
				call_f   = idx_q;
				call_o   = u_q + OW'(1);
				call_ret = bfa_pkg::S_MG_NXT;
			end
			bfa_pkg::S_MG_NXT: begin
				state_d = bfa_pkg::S_MG_RD;
			end
			bfa_pkg::S_RM_RD: begin
				state_d = bfa_pkg::S_RM_LNK;
			end
			bfa_pkg::S_RM_LNK: begin
				next_we = (rm_p != NO_LINK);
				next_wa = rm_p[FW-1:0];
				next_wd = rm_n;
				prev_we = (rm_n != NO_LINK);
				prev_wa = rm_n[FW-1:0];
				prev_wd = rm_p;
				state_d = bfa_pkg::S_RM_CLR;
			end
			bfa_pkg::S_RM_CLR: begin
				next_we = 1'b1;
				prev_we = 1'b1;
				state_d = ret_q;
			end
			bfa_pkg::S_AP_A: begin
				next_we = 1'b1;
				prev_we = 1'b1;
				if (ap_empty) begin
					state_d = ret_q;
				end else begin
					prev_wd = ap_t;
					state_d = bfa_pkg::S_AP_B;
				end
			end
			bfa_pkg::S_AP_B: begin
				next_we = 1'b1;
				next_wa = ap_t_q[FW-1:0];
				next_wd = op_f_q;
				state_d = ret_q;
			end
			bfa_pkg::S_DONE: begin
				if (!out_valid_q || m_tready) begin
					load_out = 1'b1;
					state_d  = bfa_pkg::S_IDLE;
				end
			end
			default: state_d = bfa_pkg::S_IDLE;
		endcase
		if (call_rm) state_d = bfa_pkg::S_RM_RD;
		if (call_ap) state_d = bfa_pkg::S_AP_A;
		if (fin)     state_d = bfa_pkg::S_DONE;
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bfa_pkg::S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// Memories: one write and one registered read each
	always_ff @(posedge clk) begin
		if (tag_we) tag_mem[tag_wa] <= tag_wd;
		tag_rd_q <= tag_mem[tag_ra];
	end

	always_ff @(posedge clk) begin
		if (next_we) next_mem[next_wa] <= next_wd;
		next_rd_q <= next_mem[link_ra];
	end

	always_ff @(posedge clk) begin
		if (prev_we) prev_mem[prev_wa] <= prev_wd;
		prev_rd_q <= prev_mem[link_ra];
	end

	// Free list heads and tails
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j <= TOP_ORDER; j++) begin
				head_q[j] <= (j == TOP_ORDER) ? TOP_HEAD0 : NO_LINK;
				tail_q[j] <= (j == TOP_ORDER) ? TOP_TAIL0 : NO_LINK;
			end
		end else begin
			if (state_q == bfa_pkg::S_RM_LNK) begin
				if (head_q[op_o_q] == op_f_q) head_q[op_o_q] <= rm_n;
				if (tail_q[op_o_q] == op_f_q) tail_q[op_o_q] <= rm_p;
			end
			if (state_q == bfa_pkg::S_AP_A) begin
				tail_q[op_o_q] <= op_f_q;
				if (ap_empty) head_q[op_o_q] <= op_f_q;
			end
		end
	end

	// Clearing pass counter and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == bfa_pkg::S_INIT) init_q <= init_q + FW'(1);
			if (load_out) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (call_rm || call_ap) begin
			op_f_q <= call_f;
			op_o_q <= call_o;
			ret_q  <= call_ret;
		end
		if (fin) begin
			res_status_q <= fin_status;
			res_start_q  <= fin_start;
		end
		if (load_out) begin
			out_status_q <= res_status_q;
			out_start_q  <= res_start_q;
		end
		if (state_q == bfa_pkg::S_AP_A) ap_t_q <= ap_t;
		case (state_q)
			bfa_pkg::S_IDLE: begin
				idx_q <= LW'(in_fn);
				ord_q <= OW'(in_order);
				u_q   <= OW'(in_order);
			end
			bfa_pkg::S_SCAN: begin
				if (head_q[u_q] == NO_LINK && u_q != OW'(TOP_ORDER)) u_q <= u_q + OW'(1);
			end
			bfa_pkg::S_SPLIT_RM: f_q <= head_q[u_q];
			bfa_pkg::S_SPLIT_TAG1: begin
				u_q <= u_dn;
				g_q <= LW'(gsum);
			end
			bfa_pkg::S_TAKE: begin
				f_q   <= head_q[ord_q];
				cnt_q <= '0;
			end
			bfa_pkg::S_MARK: cnt_q <= cnt_nx;
			bfa_pkg::S_FR_CHK: u_q <= '0;
			bfa_pkg::S_MG_RD: b_q <= LW'(bx);
			bfa_pkg::S_MG_T1: begin
				idx_q <= lo_f;
				b_q   <= hi_f;
			end
			bfa_pkg::S_MG_NXT: u_q <= u_q + OW'(1);
			default: ;
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {6'd0, out_start_q};

	// A refused result never names a block
	a_refuse_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata == 16'd0)
		else $error("refused result carries a block start");

	// Marking stays inside the requested block
	a_mark_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bfa_pkg::S_MARK |-> cnt_q < blk_size)
		else $error("mark counter ran past block size");

	// An accepted item leaves the idle state
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q != bfa_pkg::S_IDLE)
		else $error("sequencer stayed idle after accepting an item");

	// Linking behind a tail needs a real tail
	a_tail_valid: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bfa_pkg::S_AP_B |-> ap_t_q != NO_LINK)
		else $error("append linked behind an empty tail");

endmodule

// ----- tb/tb_alloc_scoreboard.sv -----
// Allocator state predictor and result scoreboard for the buddy frame allocator bench.
`timescale 1ns / 1ps

class alloc_scoreboard;
	localparam int NF   = 1024;
	localparam int TOPO = 7;
	localparam int NONE = NF;

	logic [3:0] tag [NF];
	int nxt [NF];
	int prv [NF];
	int head [TOPO+1];
	int tail [TOPO+1];
	logic [0:0] exp_status [$];
	logic [9:0] exp_start [$];
	int errors;
	int allocated_count;

	function new();
		errors = 0;
		reset_pool();
	endfunction

	function void reset_pool();
		for (int i = 0; i < NF; i++) begin
			tag[i] = bfa_pkg::TAG_FREE_BODY;
			nxt[i] = NONE;
			prv[i] = NONE;
		end
		for (int o = 0; o <= TOPO; o++) begin
			head[o] = NONE;
			tail[o] = NONE;
		end
		for (int b = 0; b < NF / (1 << TOPO); b++) begin
			tag[b << TOPO] = 4'(TOPO);
			link_tail(b << TOPO, TOPO);
		end
		allocated_count = 0;
	endfunction

	function void link_tail(int f, int o);
		nxt[f] = NONE;
		if (head[o] >= NONE || tail[o] >= NONE) begin
			head[o] = f;
			tail[o] = f;
			prv[f] = NONE;
		end else begin
			prv[f] = tail[o];
			nxt[tail[o]] = f;
			tail[o] = f;
		end
	endfunction

	function void unlink(int f, int o);
		int p;
		int n;
		p = prv[f];
		n = nxt[f];
		if (p < NONE) nxt[p] = n;
		if (n < NONE) prv[n] = p;
		if (head[o] == f) head[o] = n;
		if (tail[o] == f) tail[o] = p;
		prv[f] = NONE;
		nxt[f] = NONE;
	endfunction

	// Advance the pool by one accepted item and queue its result
	function void note_request(logic func, logic [3:0] ord, logic [9:0] fnum);
		int u;
		int f;
		int g;
		int idx;
		int b;
		int lo;
		int hi;
		logic st;
		logic [9:0] bs;
		st = 1'b1;
		bs = '0;
		if (func == bfa_pkg::FUNC_ALLOC) begin
			if (ord <= TOPO) begin
				u = ord;
				while (u <= TOPO && head[u] >= NONE) u++;
				if (u <= TOPO) begin
					while (u > ord) begin
						f = head[u];
						unlink(f, u);
						u--;
						g = f + (1 << u);
						tag[f] = 4'(u);
						tag[g] = 4'(u);
						link_tail(f, u);
						link_tail(g, u);
					end
					f = head[ord];
					unlink(f, ord);
					for (int i = 0; i < (1 << ord); i++) tag[f + i] = bfa_pkg::TAG_ALLOC;
					allocated_count += (1 << ord);
					st = 1'b0;
					bs = f[9:0];
				end
			end
		end else begin
			idx = fnum;
			if (tag[idx] == bfa_pkg::TAG_ALLOC) begin
				tag[idx] = 4'd0;
				link_tail(idx, 0);
				allocated_count--;
				for (int i = 0; i < TOPO; i++) begin
					b = idx ^ (1 << i);
					if (tag[b] != 4'(i)) break;
					unlink(b, i);
					unlink(idx, i);
					lo = (b < idx) ? b : idx;
					hi = (b < idx) ? idx : b;
					tag[lo] = 4'(i + 1);
					tag[hi] = bfa_pkg::TAG_FREE_BODY;
					link_tail(lo, i + 1);
					idx = lo;
				end
				st = 1'b0;
			end
		end
		exp_status.push_back(st);
		exp_start.push_back(bs);
	endfunction

	// Compare one result with the oldest expectation
	function void check_result(logic [0:0] st, logic [15:0] data);
		logic [0:0] es;
		logic [9:0] eb;
		if (exp_status.size() == 0) begin
			$display("%0t: unexpected result status %0d data %h", $time, st, data);
			errors++;
			return;
		end
		es = exp_status.pop_front();
		eb = exp_start.pop_front();
		if (st !== es) begin
			$display("%0t: status mismatch expected %0d actual %0d", $time, es, st);
			errors++;
		end
		if (data !== {6'd0, eb}) begin
			$display("%0t: block_start mismatch expected %0d actual %0d (data %h)",
				$time, eb, data[9:0], data);
			errors++;
		end
	endfunction

	// Pick a frame currently tagged allocated, or -1
	function int pick_allocated();
		int s;
		s = $urandom_range(NF - 1);
		for (int i = 0; i < NF; i++)
			if (tag[(s + i) % NF] == bfa_pkg::TAG_ALLOC) return (s + i) % NF;
		return -1;
	endfunction

	function int pending();
		return exp_status.size();
	endfunction
endclass

// ----- tb/tb.sv -----
// Top-level bench: drives requests into the allocator and checks every result.
`timescale 1ns / 1ps

module tb;

	localparam int WATCHDOG_LIMIT = 20000;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [15:0] s_tdata;
	logic [0:0] s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [15:0] m_tdata;
	logic [0:0] m_tuser;

	alloc_scoreboard pool;
	bit long_hold;
	int idle_cycles;

	buddy_frame_allocator_top uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Offer one item and hold it until accepted
	task automatic send_request(logic func, logic [3:0] ord, logic [9:0] fnum, bit gaps);
		int wait_n;
		wait_n = gaps ? $urandom_range(14) : 0;
		@(negedge clk);
		repeat (wait_n) @(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= func;
		s_tdata <= {2'b00, fnum, ord};
		do @(posedge clk); while (!s_tready);
		pool.note_request(func, ord, fnum);
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	task automatic send_free_of_allocated(bit gaps);
		int f;
		f = pool.pick_allocated();
		if (f >= 0) send_request(bfa_pkg::FUNC_FREE, 4'($urandom_range(15)), 10'(f), gaps);
		else send_request(bfa_pkg::FUNC_ALLOC, 4'($urandom_range(7)), 10'($urandom), gaps);
	endtask

	task automatic wait_drained();
		while (pool.pending() != 0) @(negedge clk);
	endtask

	// Receiver: random stalls, with one long hold-off
	initial begin
		int n;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold) begin
				m_tready <= 1'b0;
				repeat (400) @(negedge clk);
				long_hold = 1'b0;
			end
			n = ($urandom_range(3) == 0) ? 0 : $urandom_range(14);
			if (n > 0) begin
				m_tready <= 1'b0;
				repeat (n - 1) @(negedge clk);
				@(negedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	// Check results at the rising edge
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) pool.check_result(m_tuser, m_tdata);
	end

	// Watchdog on cycles with no handshake
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Stimulus
	initial begin
		int r;
		pool = new();
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		arst_n = 1'b0;
		long_hold = 1'b0;
		idle_cycles = 0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// Directed: every order, bad orders, bad frees, merges, exhaustion
		send_request(bfa_pkg::FUNC_ALLOC, 4'd0, 10'h3ff, 1'b0);
		send_request(bfa_pkg::FUNC_ALLOC, 4'd7, 10'd0, 1'b0);
		send_request(bfa_pkg::FUNC_ALLOC, 4'd8, 10'd0, 1'b0);
		send_request(bfa_pkg::FUNC_ALLOC, 4'd15, 10'h3ff, 1'b0);
		for (int o = 1; o < 7; o++) send_request(bfa_pkg::FUNC_ALLOC, 4'(o), 10'h2aa, 1'b0);
		send_request(bfa_pkg::FUNC_FREE, 4'd0, 10'd0, 1'b0);
		send_request(bfa_pkg::FUNC_FREE, 4'd0, 10'd0, 1'b0);
		send_request(bfa_pkg::FUNC_FREE, 4'd15, 10'h3ff, 1'b0);
		send_request(bfa_pkg::FUNC_FREE, 4'd5, 10'd1, 1'b0);
		send_request(bfa_pkg::FUNC_FREE, 4'd3, 10'd128, 1'b0);
		for (int k = 0; k < 9; k++) send_request(bfa_pkg::FUNC_ALLOC, 4'd7, 10'h155, 1'b0);
		wait_drained();
		for (int k = 0; k < 2; k++) send_free_of_allocated(1'b0);

		// Fill the block while the receiver holds off
		long_hold = 1'b1;
		for (int k = 0; k < 12; k++)
			send_request(bfa_pkg::FUNC_ALLOC, 4'($urandom_range(3)), 10'd0, 1'b0);
		wait_drained();

		// Random: mostly frees of live frames and modest allocations
		for (int k = 0; k < 1170; k++) begin
			r = $urandom_range(99);
			if (r < 45) send_free_of_allocated(($urandom_range(4) != 0));
			else if (r < 85) send_request(bfa_pkg::FUNC_ALLOC, 4'($urandom_range(3)),
				10'($urandom), ($urandom_range(4) != 0));
			else if (r < 92) send_request(bfa_pkg::FUNC_ALLOC, 4'($urandom_range(15)),
				10'($urandom), ($urandom_range(4) != 0));
			else send_request(bfa_pkg::FUNC_FREE, 4'($urandom_range(15)), 10'($urandom),
				($urandom_range(4) != 0));
			if (k == 600) wait_drained();
		end
		wait_drained();
		repeat (300) @(negedge clk);
		if (pool.errors == 0 && pool.pending() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule

// ----- files.f -----
rtl/bfa_pkg.sv
rtl/buddy_frame_allocator_top.sv
tb/tb_alloc_scoreboard.sv
tb/tb.sv
